// ===== hdl/text_console_cell_engine_top_defines.svh =====
// Assertion macros for the text console cell engine
`ifndef TEXT_CONSOLE_CELL_ENGINE_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CELL_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define TCE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked outside reset
`define TCE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TCE_ASSERT_SAME(label, ante, cons, msg)
`define TCE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== hdl/tce_pkg.sv =====
package tce_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;

	localparam int ROW_W  = $clog2(ROWS + 1);
	localparam int COL_W  = $clog2(COLUMNS + 1);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CNT_W  = $clog2(CELLS + 1);
	localparam int LIN_W  = $clog2(CELLS + COLUMNS + 1);
	localparam int CELL_W = 18;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [4:0] COLOUR_DEFAULT = 5'd16;
	localparam logic [3:0] BG_RESET = 4'd0;
	localparam logic [3:0] FG_RESET = 4'd7;

	typedef enum logic [2:0] {
		OP_PUT    = 3'd0,
		OP_FLOOR  = 3'd1,
		OP_COLOUR = 3'd2,
		OP_CLEAR  = 3'd3,
		OP_SCROLL = 3'd4,
		OP_READ   = 3'd5
	} tce_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_NL,
		ST_BS_RD,
		ST_BS_CHK,
		ST_SWEEP,
		ST_READ,
		ST_DONE
	} tce_state_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] ch;
		logic [4:0] bg_color;
		logic [4:0] fg_color;
		logic [4:0] scroll_rows;
		logic [4:0] cell_row;
		logic [6:0] cell_col;
	} tce_cmd_t;

	typedef struct packed {
		logic       status;
		logic [4:0] old_bg;
		logic [4:0] old_fg;
		logic [7:0] read_char;
		logic [7:0] read_attr;
	} tce_rsp_t;

	// flags[0] explicit foreground, flags[1] explicit background
	typedef struct packed {
		logic [1:0] flags;
		logic [7:0] attr;
		logic [7:0] chr;
	} tce_cell_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		tce_cell_t         wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} tce_mem_req_t;

	function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		logic [LIN_W-1:0] lin;
		lin = LIN_W'(r * COLUMNS) + LIN_W'(c);
		return lin[ADDR_W-1:0];
	endfunction

	function automatic logic [LIN_W-1:0] lin_pos(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
		return LIN_W'(r * COLUMNS) + LIN_W'(c);
	endfunction

endpackage

// ===== hdl/tce_ram.sv =====
module tce_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/tce_ctrl.sv =====
module tce_ctrl import tce_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_stall,
	input  tce_cmd_t     cmd,
	input  logic         rsp_ready,
	output logic         done,
	output tce_rsp_t     res,
	output tce_mem_req_t mem,
	input  tce_cell_t    rdata
);

	tce_state_t state_q, state_d;

	logic [ROW_W-1:0]  row_q, row_d, flr_row_q, flr_row_d;
	logic [COL_W-1:0]  col_q, col_d, flr_col_q, flr_col_d;
	logic [3:0]        bg_q, bg_d, fg_q, fg_d;
	tce_cmd_t          cmd_q;
	tce_rsp_t          res_q, res_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [ADDR_W-1:0] offset_q, offset_d;
	logic [CNT_W-1:0]  copy_end_q, copy_end_d;
	tce_cell_t         fill_q, fill_d;
	logic              recol_q, recol_d;
	logic              init_q, init_d;
	logic              v_s1, v_d;
	logic [ADDR_W-1:0] dst_s1, dst_d;

	// wrapped cursor and helpers for execute
	logic [ROW_W-1:0] w_row, n_rows;
	logic [COL_W-1:0] w_col;
	logic [7:0]       cur_attr;
	tce_cell_t        space_cell, put_cell, recol_cell;

	always_comb begin
		cur_attr   = {bg_q, fg_q};
		space_cell = '{flags: 2'b00, attr: cur_attr, chr: CH_SPACE};
		w_row      = (col_q >= COL_W'(COLUMNS)) ? row_q + ROW_W'(1) : row_q;
		w_col      = (col_q >= COL_W'(COLUMNS)) ? '0 : col_q;
		n_rows     = (cmd_q.scroll_rows > 5'(ROWS)) ? ROW_W'(ROWS) : ROW_W'(cmd_q.scroll_rows);
		put_cell.chr   = cmd_q.ch;
		put_cell.flags = {cmd_q.bg_color <= 5'd15, cmd_q.fg_color <= 5'd15};
		put_cell.attr  = {(cmd_q.bg_color <= 5'd15) ? cmd_q.bg_color[3:0] : bg_q,
			(cmd_q.fg_color <= 5'd15) ? cmd_q.fg_color[3:0] : fg_q};
		recol_cell       = rdata;
		recol_cell.attr  = {rdata.flags[1] ? rdata.attr[7:4] : bg_q,
			rdata.flags[0] ? rdata.attr[3:0] : fg_q};
	end

	// state and payload registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			row_q      <= '0;
			col_q      <= '0;
			flr_row_q  <= '0;
			flr_col_q  <= '0;
			bg_q       <= BG_RESET;
			fg_q       <= FG_RESET;
			cnt_q      <= '0;
			offset_q   <= '0;
			copy_end_q <= '0;
			fill_q     <= '0;
			recol_q    <= 1'b0;
			init_q     <= 1'b1;
			v_s1       <= 1'b0;
		end else begin
			state_q    <= state_d;
			row_q      <= row_d;
			col_q      <= col_d;
			flr_row_q  <= flr_row_d;
			flr_col_q  <= flr_col_d;
			bg_q       <= bg_d;
			fg_q       <= fg_d;
			cnt_q      <= cnt_d;
			offset_q   <= offset_d;
			copy_end_q <= copy_end_d;
			fill_q     <= fill_d;
			recol_q    <= recol_d;
			init_q     <= init_d;
			v_s1       <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
		res_q  <= res_d;
		dst_s1 <= dst_d;
	end

	// next state, memory access and result
	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		col_d      = col_q;
		flr_row_d  = flr_row_q;
		flr_col_d  = flr_col_q;
		bg_d       = bg_q;
		fg_d       = fg_q;
		cnt_d      = cnt_q;
		offset_d   = offset_q;
		copy_end_d = copy_end_q;
		fill_d     = fill_q;
		recol_d    = recol_q;
		init_d     = init_q;
		v_d        = 1'b0;
		dst_d      = dst_s1;
		res_d      = res_q;
		mem        = '0;
		done       = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					res_d   = '0;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_DONE;
				case (cmd_q.op)
					OP_PUT: begin
						row_d = w_row;
						col_d = w_col;
						if (w_row >= ROW_W'(ROWS)) begin
							res_d.status = 1'b1;
						end else if (cmd_q.ch == CH_NL) begin
							state_d = ST_NL;
						end else if (cmd_q.ch == CH_BS) begin
							if (lin_pos(w_row, w_col) > lin_pos(flr_row_q, flr_col_q)) begin
								if (w_col != '0) begin
									col_d     = w_col - COL_W'(1);
									mem.we    = 1'b1;
									mem.waddr = cell_addr(w_row, col_d);
									mem.wdata = space_cell;
								end else begin
									row_d   = w_row - ROW_W'(1);
									col_d   = COL_W'(COLUMNS - 1);
									state_d = ST_BS_RD;
								end
							end
						end else begin
							mem.we    = 1'b1;
							mem.waddr = cell_addr(w_row, w_col);
							mem.wdata = put_cell;
							col_d     = w_col + COL_W'(1);
						end
					end
					OP_FLOOR: begin
						flr_row_d = row_q;
						flr_col_d = col_q;
					end
					OP_COLOUR: begin
						if (cmd_q.bg_color > 5'd15 || cmd_q.fg_color > 5'd15) begin
							res_d.old_bg = COLOUR_DEFAULT;
							res_d.old_fg = COLOUR_DEFAULT;
						end else begin
							res_d.old_bg = {1'b0, bg_q};
							res_d.old_fg = {1'b0, fg_q};
							bg_d       = cmd_q.bg_color[3:0];
							fg_d       = cmd_q.fg_color[3:0];
							cnt_d      = '0;
							offset_d   = '0;
							copy_end_d = CNT_W'(CELLS);
							recol_d    = 1'b1;
							state_d    = ST_SWEEP;
						end
					end
					OP_CLEAR: begin
						row_d      = '0;
						col_d      = '0;
						flr_row_d  = '0;
						flr_col_d  = '0;
						cnt_d      = '0;
						copy_end_d = '0;
						fill_d     = space_cell;
						recol_d    = 1'b0;
						state_d    = ST_SWEEP;
					end
					OP_SCROLL: begin
						offset_d   = ADDR_W'(n_rows * COLUMNS);
						copy_end_d = CNT_W'(CELLS) - CNT_W'(offset_d);
						cnt_d      = '0;
						fill_d     = '{flags: 2'b00, attr: cur_attr, chr: 8'h00};
						recol_d    = 1'b0;
						row_d      = ROW_W'(ROWS) - n_rows;
						col_d      = '0;
						if (flr_row_q >= n_rows) begin
							flr_row_d = flr_row_q - n_rows;
						end else begin
							flr_row_d = '0;
							flr_col_d = '0;
						end
						state_d = ST_SWEEP;
					end
					OP_READ: begin
						if (cmd_q.cell_row < 5'(ROWS) && cmd_q.cell_col < 7'(COLUMNS)) begin
							mem.re    = 1'b1;
							mem.raddr = cell_addr(ROW_W'(cmd_q.cell_row),
								COL_W'(cmd_q.cell_col));
							state_d   = ST_READ;
						end
					end
					default: begin
					end
				endcase
			end
			// newline: blank the rest of the row, one cell a cycle
			ST_NL: begin
				mem.we    = 1'b1;
				mem.waddr = cell_addr(row_q, col_q);
				mem.wdata = space_cell;
				if (col_q == COL_W'(COLUMNS - 1)) begin
					col_d   = '0;
					row_d   = row_q + ROW_W'(1);
					state_d = ST_DONE;
				end else begin
					col_d = col_q + COL_W'(1);
				end
			end
			ST_BS_RD: begin
				mem.re    = 1'b1;
				mem.raddr = cell_addr(row_q, col_q);
				state_d   = ST_BS_CHK;
			end
			// skip trailing spaces back to column 0
			ST_BS_CHK: begin
				if (rdata.chr == CH_SPACE && col_q != '0) begin
					col_d   = col_q - COL_W'(1);
					state_d = ST_BS_RD;
				end else begin
					mem.we    = 1'b1;
					mem.waddr = cell_addr(row_q, col_q);
					mem.wdata = space_cell;
					state_d   = ST_DONE;
				end
			end
			// whole-store walk: copy/recolour through a read stage, then fill
			ST_SWEEP: begin
				if (v_s1) begin
					mem.we    = 1'b1;
					mem.waddr = dst_s1;
					mem.wdata = recol_q ? recol_cell : rdata;
				end
				if (cnt_q < CNT_W'(CELLS)) begin
					if (cnt_q < copy_end_q) begin
						mem.re    = 1'b1;
						mem.raddr = ADDR_W'(cnt_q + CNT_W'(offset_q));
						v_d       = 1'b1;
						dst_d     = cnt_q[ADDR_W-1:0];
						cnt_d     = cnt_q + CNT_W'(1);
					end else if (!v_s1) begin
						mem.we    = 1'b1;
						mem.waddr = cnt_q[ADDR_W-1:0];
						mem.wdata = fill_q;
						cnt_d     = cnt_q + CNT_W'(1);
					end
				end else if (!v_s1) begin
					init_d  = 1'b0;
					state_d = init_q ? ST_IDLE : ST_DONE;
				end
			end
			ST_READ: begin
				res_d.read_char = rdata.chr;
				res_d.read_attr = rdata.attr;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_ready) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign res       = res_q;

endmodule

// ===== hdl/text_console_cell_engine_top.sv =====
// Newline blanks the rest of the row; backspace at column 0 walks back along the row above,
// with a read and a check per cell walked back.
// An accepted colour change, clear and scroll walk all 2000 cells, one a cycle except where
// the copy stage drains before the fill. One command at a time. Reset is asynchronous,
// active low; a clearing pass then zeroes the cell memory while cmd_stall stays high.
`include "text_console_cell_engine_top_defines.svh"

module text_console_cell_engine_top import tce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  tce_cmd_t cmd,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output tce_rsp_t rsp
);

	tce_mem_req_t mem;
	tce_cell_t    rdata;
	tce_rsp_t     res;
	logic         done;
	logic         rsp_ready;
	logic         rsp_valid_q;
	tce_rsp_t     rsp_q;

	tce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_ready (rsp_ready),
		.done      (done),
		.res       (res),
		.mem       (mem),
		.rdata     (rdata)
	);

	tce_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	// result register
	assign rsp_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`TCE_ASSERT_SAME(a_done_slot_free, done, rsp_ready, "result produced into a full slot")
	`TCE_ASSERT_NEXT(a_cmd_busy, cmd_valid && !cmd_stall, cmd_stall && !done, "idle after transfer")
	`TCE_ASSERT_SAME(a_mem_no_overlap, mem.we && mem.re, mem.waddr != mem.raddr, "same cell hit")

endmodule
